[design/sorted_table_binary_search_unit_assert.svh]
// Assertion macros for the sorted table binary search unit.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STBS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define STBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/stbs_pkg.sv]
// Package: widths, codes, state and command types of the binary search unit.
package stbs_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int BND_W       = IDX_W + 1;
	localparam int CNT_W       = 8;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SEARCH = 1'b1
	} stbs_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_HOLD
	} stbs_state_t;

	// Controller to datapath
	typedef struct packed {
		logic write;      // store the load item's entry
		logic init;       // start a search: bounds, key, first probe read
		logic step;       // narrow bounds and read the next probe
		logic finish;     // park the result in the pending register
		logic emit;       // load the output register
		logic emit_pend;  // output comes from the pending register
		logic res_val;    // result value for finish or a direct emit
	} stbs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;      // search range is empty
		logic match;      // probed entry equals the key
		logic crossed;    // bounds cross after this probe
		logic out_free;   // output register can take a result
	} stbs_stat_t;

endpackage

[design/stbs_channels.sv]
// Channel interfaces: request, response and configuration write.
interface stbs_req_if import stbs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] search_key;

	modport source (output valid, operation, entry_index, entry_value, search_key,
		input ready);
	modport sink (input valid, operation, entry_index, entry_value, search_key,
		output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
	logic valid;
	logic ready;
	logic found;

	modport source (output valid, found, input ready);
	modport sink (input valid, found, output ready);
endinterface

interface stbs_cfg_if import stbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[design/stbs_datapath.sv]
// Datapath: table memory, search bounds, probe compare and result registers.
module stbs_datapath import stbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stbs_cmd_t                cmd,
	output stbs_stat_t               stat,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	input  logic signed [DATA_W-1:0] search_key,
	input  logic                     cfg_valid,
	input  logic [CNT_W-1:0]         cfg_data,
	input  logic                     rsp_ready,
	output logic                     rsp_valid,
	output logic                     rsp_found
);

	logic [DATA_W-1:0] table_mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [CNT_W-1:0]  count_q;
	logic [BND_W-1:0]  low_q;
	logic [BND_W-1:0]  hi_q;
	logic [IDX_W-1:0]  mid_q;
	logic [DATA_W-1:0] key_q;
	logic              res_q;
	logic              found_q;
	logic              out_valid_q;

	logic [BND_W-1:0]  count_sat;
	logic [IDX_W-1:0]  mid_init;
	logic              probe_lt;
	logic [BND_W-1:0]  low_nxt;
	logic [BND_W-1:0]  hi_nxt;
	logic [BND_W-1:0]  span_nxt;
	logic [IDX_W-1:0]  mid_nxt;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_en;

	// Hold the entry count written over the configuration channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	// Clamp the count to the table depth
	assign count_sat = (count_q > CNT_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
		: BND_W'(count_q);
	assign mid_init  = IDX_W'((count_sat - BND_W'(1)) >> 1);

	// Compare the probed entry and narrow the bounds (high bound exclusive)
	assign probe_lt = $signed(rd_data_q) < $signed(key_q);
	assign low_nxt  = probe_lt ? (BND_W'(mid_q) + BND_W'(1)) : low_q;
	assign hi_nxt   = probe_lt ? hi_q : BND_W'(mid_q);
	assign span_nxt = hi_nxt - low_nxt - BND_W'(1);
	assign mid_nxt  = IDX_W'(low_nxt + (span_nxt >> 1));

	assign stat.empty    = (count_sat == '0);
	assign stat.match    = (rd_data_q == key_q);
	assign stat.crossed  = (low_nxt >= hi_nxt);
	assign stat.out_free = !out_valid_q || rsp_ready;

	// Pick the probe address
	assign rd_addr = cmd.init ? mid_init : mid_nxt;
	assign rd_en   = cmd.init || cmd.step;

	// Advance the search bounds
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			low_q <= '0;
			hi_q  <= count_sat;
			key_q <= search_key;
			mid_q <= rd_addr;
		end else if (cmd.step) begin
			low_q <= low_nxt;
			hi_q  <= hi_nxt;
			mid_q <= rd_addr;
		end
	end

	// Write port of the table
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			table_mem[entry_index] <= entry_value;
		end
	end

	// Registered read port of the table
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= table_mem[rd_addr];
		end
	end

	// Park a result while the output register is occupied
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= cmd.res_val;
		end
	end

	// Output register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_q <= cmd.emit_pend ? res_q : cmd.res_val;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_found = found_q;

endmodule

[design/stbs_controller.sv]
// Controller: sequences loads, search probes and result hand-off.
module stbs_controller import stbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_operation,
	output logic       req_ready,
	input  stbs_stat_t stat,
	output stbs_cmd_t  cmd
);

	stbs_state_t state_q;
	stbs_state_t state_nxt;
	logic        is_search;

	assign is_search = (req_operation == OP_SEARCH);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && is_search) begin
					if (!stat.empty) begin
						state_nxt = ST_PROBE;
					end else if (!stat.out_free) begin
						state_nxt = ST_HOLD;
					end
				end
			end
			ST_PROBE: begin
				if (stat.match || stat.crossed) begin
					state_nxt = stat.out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && !is_search) begin
					cmd.write = 1'b1;
				end else if (req_valid) begin
					cmd.init    = 1'b1;
					cmd.res_val = 1'b0;
					if (stat.empty) begin
						cmd.emit   = stat.out_free;
						cmd.finish = !stat.out_free;
					end
				end
			end
			ST_PROBE: begin
				cmd.res_val = stat.match;
				if (stat.match || stat.crossed) begin
					cmd.emit   = stat.out_free;
					cmd.finish = !stat.out_free;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_HOLD: begin
				cmd.emit      = stat.out_free;
				cmd.emit_pend = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[design/sorted_table_binary_search_unit.sv]
// Top level of the sorted table binary search unit.
//
// Channels: req carries load and search items, rsp carries one found bit per
// search, cfg writes the entry count a search covers (always ready).
// A load item writes one table entry in the cycle it transfers and gives no
// response. A search item runs one probe per cycle against the registered
// read port of the table memory: at most 8 probes for 128 entries. The
// response is registered in the output register, and a search over an
// empty range answers without probing the table.
// One item is worked at a time: req is ready again in the cycle after a
// load, and in the cycle after the response is loaded into the output
// register.
// The output register keeps the block apart from a stalled receiver: a
// finished search waits in a pending register while rsp is stalled, and
// req stays low until that result moves on.
// Reset clears the entry count to zero, the output valid and the state
// machine; table contents are undefined until loaded.
module sorted_table_binary_search_unit import stbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	stbs_req_if.sink   req,
	stbs_rsp_if.source rsp,
	stbs_cfg_if.sink   cfg
);

	`include "sorted_table_binary_search_unit_assert.svh"

	stbs_cmd_t  cmd;
	stbs_stat_t stat;

	assign cfg.ready = 1'b1;

	stbs_controller u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	stbs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.search_key  (req.search_key),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.data),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_found   (rsp.found)
	);

	// A result is loaded only into a free output register
	`STBS_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit, (!rsp.valid || rsp.ready), "result loaded over a pending response")
	// A loaded result is offered in the next cycle
	`STBS_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, rsp.valid, "loaded result not offered")
	// No new item is taken while the search continues
	`STBS_ASSERT_NEXT(a_step_busy, clk, arst_n, cmd.step, !req.ready, "request taken during a search")

endmodule
